// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

	// input mode codes
	typedef enum logic [2:0] {
		MODE_SDEC = 3'd0,
		MODE_UDEC = 3'd1,
		MODE_LHEX = 3'd2,
		MODE_UHEX = 3'd3,
		MODE_PTR  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SKIP,
		ST_PREFIX,
		ST_EMIT
	} state_t;

	localparam int WORD_BITS  = 32;
	localparam int VALUE_BITS = 64;
	localparam int DEC_DIGITS = 10;
	localparam int BCD_BITS   = 4 * DEC_DIGITS;
	localparam int MAX_CHARS  = 18;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2d;
	localparam logic [6:0] CH_X     = 7'h78;
	localparam logic [6:0] CH_LA    = 7'h61;
	localparam logic [6:0] CH_UA    = 7'h41;

	// ASCII for one digit; letters for 10..15
	function automatic logic [6:0] digit_char(logic [3:0] d, logic upper);
		logic [6:0] base;
		base = upper ? CH_UA : CH_LA;
		if (d < 4'd10)
			return CH_ZERO + {3'b000, d};
		else
			return base + {3'b000, d} - 7'd10;
	endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// Integer to ASCII formatter.
// Input channel (num_valid / num_stall): one number per item with a mode:
// signed or unsigned decimal on the low 32 bits, lower or upper hex on 32
// bits, or a pointer in lowercase hex with a "0x" prefix.
// Output channel (char_valid / char_stall): one item per character, most
// significant digit first, no leading zeros, with a running count and a
// last flag. Unused modes are accepted and produce nothing.
// Timing: decimal numbers go through a bit-serial binary to BCD converter,
// one value bit per cycle. Hex is loaded directly. Leading zero digits are
// then dropped one per cycle, and characters leave one per cycle from the
// output register while the receiver does not stall. A number holds the
// input while it is accepted, converted (decimal only), stripped of its
// leading zeros and sent out character by character, the minus sign or
// the 0x prefix first.
// num_stall is high from acceptance until the final character has been
// placed in the output register; the next number can be taken while that
// character still waits. When the receiver stalls, the output register
// holds its character and the shifter waits to send. Reset clears the
// control state and drops any pending character.
module integer_to_ascii_formatter_unit #(
	parameter int POINTER_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        num_valid,
	output logic        num_stall,
	input  logic [2:0]  mode,
	input  logic [63:0] value,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [6:0]  char_code,
	output logic [4:0]  char_count,
	output logic        last_char
);

	// pointer digits are left aligned in the shifter
	localparam int PTR_DIGITS = (POINTER_BITS + 3) / 4;
	localparam int PTR_SHIFT  = itoa_pkg::VALUE_BITS - 4 * PTR_DIGITS;
	localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (itoa_pkg::VALUE_BITS - POINTER_BITS);

	itoa_pkg::state_t state_q, state_d;

	logic [63:0] dig_q;     // digits, most significant at top
	logic [31:0] bin_q;     // binary for the BCD converter
	logic [4:0]  bitcnt_q;  // converter step
	logic [4:0]  ndig_q;    // digits left in dig_q
	logic [4:0]  cnt_q;     // characters sent so far
	logic [1:0]  pfx_q;     // prefix characters left
	logic        minus_q;
	logic        upper_q;
	logic        ptr_q;

	logic        out_free;
	logic        emit;
	logic [6:0]  emit_code;
	logic        emit_last;
	logic [39:0] bcd_adj;
	logic [39:0] bcd_next;
	logic [31:0] neg_mag;
	logic        neg_in;

	assign out_free = !char_valid || !char_stall;
	assign neg_mag  = ~value[31:0] + 32'd1;
	assign neg_in   = (mode == itoa_pkg::MODE_SDEC) && value[31];

	// double dabble: add 3 to each BCD digit of 5 or more, then shift in a bit
	always_comb begin
		for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ?
				dig_q[4*i +: 4] + 4'd3 : dig_q[4*i +: 4];
		end
		bcd_next = {bcd_adj[38:0], bin_q[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_code = itoa_pkg::digit_char(dig_q[63:60], upper_q);
		emit_last = 1'b0;
		num_stall = 1'b1;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				num_stall = 1'b0;
				if (num_valid) begin
					case (mode) inside
						itoa_pkg::MODE_SDEC,
						itoa_pkg::MODE_UDEC: state_d = itoa_pkg::ST_DABBLE;
						itoa_pkg::MODE_LHEX,
						itoa_pkg::MODE_UHEX,
						itoa_pkg::MODE_PTR:  state_d = itoa_pkg::ST_SKIP;
						default:             state_d = itoa_pkg::ST_IDLE;
					endcase
				end
			end
			itoa_pkg::ST_DABBLE: begin
				if (bitcnt_q == 5'(itoa_pkg::WORD_BITS - 1))
					state_d = itoa_pkg::ST_SKIP;
			end
			itoa_pkg::ST_SKIP: begin
				if (!(ndig_q > 5'd1 && dig_q[63:60] == 4'd0))
					state_d = (minus_q || ptr_q) ? itoa_pkg::ST_PREFIX : itoa_pkg::ST_EMIT;
			end
			itoa_pkg::ST_PREFIX: begin
				emit_code = minus_q ? itoa_pkg::CH_MINUS :
					(pfx_q == 2'd2 ? itoa_pkg::CH_ZERO : itoa_pkg::CH_X);
				if (out_free) begin
					emit = 1'b1;
					if (minus_q || pfx_q == 2'd1)
						state_d = itoa_pkg::ST_EMIT;
				end
			end
			itoa_pkg::ST_EMIT: begin
				emit_last = (ndig_q == 5'd1);
				if (out_free) begin
					emit = 1'b1;
					if (ndig_q == 5'd1)
						state_d = itoa_pkg::ST_IDLE;
				end
			end
			default: state_d = itoa_pkg::ST_IDLE;
		endcase
	end

	// digit shifter and converter
	always_ff @(posedge clk) begin
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				cnt_q    <= 5'd0;
				bitcnt_q <= 5'd0;
				minus_q  <= neg_in;
				ptr_q    <= (mode == itoa_pkg::MODE_PTR);
				upper_q  <= (mode == itoa_pkg::MODE_UHEX);
				pfx_q    <= 2'd2;
				bin_q    <= neg_in ? neg_mag : value[31:0];
				case (mode) inside
					itoa_pkg::MODE_SDEC,
					itoa_pkg::MODE_UDEC: begin
						dig_q  <= '0;
						ndig_q <= 5'd8;
					end
					itoa_pkg::MODE_PTR: begin
						dig_q  <= (value & PTR_MASK) << PTR_SHIFT;
						ndig_q <= 5'(PTR_DIGITS);
					end
					default: begin
						dig_q  <= {value[31:0], 32'd0};
						ndig_q <= 5'd8;
					end
				endcase
			end
			itoa_pkg::ST_DABBLE: begin
				bitcnt_q <= bitcnt_q + 5'd1;
				bin_q    <= {bin_q[30:0], 1'b0};
				if (bitcnt_q == 5'(itoa_pkg::WORD_BITS - 1)) begin
					dig_q  <= {bcd_next, 24'd0};
					ndig_q <= 5'(itoa_pkg::DEC_DIGITS);
				end else begin
					dig_q[39:0] <= bcd_next;
				end
			end
			itoa_pkg::ST_SKIP: begin
				if (ndig_q > 5'd1 && dig_q[63:60] == 4'd0) begin
					dig_q  <= {dig_q[59:0], 4'd0};
					ndig_q <= ndig_q - 5'd1;
				end
			end
			itoa_pkg::ST_PREFIX: begin
				if (emit) begin
					cnt_q <= cnt_q + 5'd1;
					pfx_q <= pfx_q - 2'd1;
				end
			end
			itoa_pkg::ST_EMIT: begin
				if (emit) begin
					cnt_q  <= cnt_q + 5'd1;
					dig_q  <= {dig_q[59:0], 4'd0};
					ndig_q <= ndig_q - 5'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (emit) begin
			char_valid <= 1'b1;
		end else if (!char_stall) begin
			char_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_code  <= emit_code;
			char_count <= cnt_q + 5'd1;
			last_char  <= emit_last;
		end
	end

endmodule

// ===== rtl/itoa_chk.sv =====
module itoa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        num_valid,
	input logic        num_stall,
	input logic [2:0]  mode,
	input logic [63:0] value,
	input logic        char_valid,
	input logic        char_stall,
	input logic [6:0]  char_code,
	input logic [4:0]  char_count,
	input logic        last_char
);

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_code) &&
			$stable(char_count) && $stable(last_char))
		else $error("stalled character changed");

	// no new number while a number is still mid-output
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !last_char |-> num_stall)
		else $error("input open before final character");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> char_count != 5'd0 && char_count <= 5'(itoa_pkg::MAX_CHARS))
		else $error("character count out of range");

	// back to back characters count up by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && $past(char_valid && !char_stall && !last_char) |->
			char_count == $past(char_count) + 5'd1)
		else $error("character count skipped");

endmodule

bind integer_to_ascii_formatter_unit itoa_chk u_itoa_chk (.*);

// ===== bench/tb_integer_to_ascii_formatter_unit.sv =====
module tb_integer_to_ascii_formatter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PTR_BITS     = 64;
	localparam int RANDOM_ITEMS = 290;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PCT     = 18;
	// window with no idling on either side
	localparam int QUIET_FROM   = 5000;
	localparam int QUIET_TO     = 10000;

	// one number waiting to be sent; hold marks a pause until all chars are back
	typedef struct {
		logic [2:0]  md;
		logic [63:0] val;
		bit          hold;
	} number_item_t;

	typedef struct {
		logic [6:0] code;
		logic [4:0] count;
		logic       last;
	} char_item_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        num_valid  = 1'b0;
	logic        num_stall;
	logic [2:0]  mode       = '0;
	logic [63:0] value      = '0;
	logic        char_valid;
	logic        char_stall = 1'b0;
	logic [6:0]  char_code;
	logic [4:0]  char_count;
	logic        last_char;

	number_item_t pending_numbers[$];
	char_item_t   expected_chars[$];

	int cycle_count    = 0;
	int mismatch_count = 0;
	int chars_checked  = 0;
	int numbers_taken[8];
	logic quiet;

	integer_to_ascii_formatter_unit #(
		.POINTER_BITS(PTR_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.mode      (mode),
		.value     (value),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code (char_code),
		.char_count(char_count),
		.last_char (last_char)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars still expected",
				cycle_count, expected_chars.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	assign quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;

	// ASCII of one digit in the selected case
	function automatic logic [6:0] hex_glyph(logic [3:0] d, bit upper);
		if (d < 4'd10)
			return itoa_pkg::CH_ZERO + 7'(d);
		return (upper ? itoa_pkg::CH_UA : itoa_pkg::CH_LA) + 7'(d - 4'd10);
	endfunction

	// Work out the characters of one number and queue them in order.
	// Digits come out least significant first from repeated division,
	// then go out reversed behind the sign or the 0x prefix.
	task automatic format_number(logic [2:0] md, logic [63:0] val);
		logic [63:0] rest;
		logic [63:0] radix;
		logic [63:0] ptr_mask;
		logic [3:0]  digits[20];
		logic [31:0] low;
		bit          upper;
		bit          minus;
		bit          prefix;
		int          n;
		int          total;
		int          k;
		radix  = 64'd10;
		upper  = 1'b0;
		minus  = 1'b0;
		prefix = 1'b0;
		low    = val[31:0];
		ptr_mask = (PTR_BITS >= 64) ? '1 : ((64'd1 << PTR_BITS) - 64'd1);
		case (md)
			itoa_pkg::MODE_SDEC: begin
				// magnitude worked at 64 bits so the minimum stays 2147483648
				minus = low[31];
				rest  = minus ? (64'h1_0000_0000 - {32'd0, low}) : {32'd0, low};
			end
			itoa_pkg::MODE_UDEC: rest = {32'd0, low};
			itoa_pkg::MODE_LHEX: begin
				rest  = {32'd0, low};
				radix = 64'd16;
			end
			itoa_pkg::MODE_UHEX: begin
				rest  = {32'd0, low};
				radix = 64'd16;
				upper = 1'b1;
			end
			itoa_pkg::MODE_PTR: begin
				rest   = val & ptr_mask;
				radix  = 64'd16;
				prefix = 1'b1;
			end
			default: return;    // unused modes give nothing
		endcase
		n = 0;
		do begin
			digits[n] = 4'(rest % radix);
			rest      = rest / radix;
			n++;
		end while (rest != 0 && n < 20);
		total = n + (minus ? 1 : 0) + (prefix ? 2 : 0);
		k = 0;
		if (minus) begin
			expected_chars.push_back('{itoa_pkg::CH_MINUS, 5'(k + 1), k + 1 == total});
			k++;
		end
		if (prefix) begin
			expected_chars.push_back('{itoa_pkg::CH_ZERO, 5'(k + 1), 1'b0});
			k++;
			expected_chars.push_back('{itoa_pkg::CH_X, 5'(k + 1), k + 1 == total});
			k++;
		end
		for (int i = n - 1; i >= 0; i--) begin
			expected_chars.push_back('{hex_glyph(digits[i], upper), 5'(k + 1),
				k + 1 == total});
			k++;
		end
	endtask

	// random value with a spread of digit counts and sign patterns
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(4))
			0: ;
			1: v = v >> $urandom_range(63);
			2: v = 64'($urandom_range(20));
			3: v = {v[63:32], 32'd0 - 32'($urandom_range(1, 20))};
			default: v = 64'd1 << $urandom_range(63);
		endcase
		return v;
	endfunction

	function automatic void queue_number(logic [2:0] md, logic [63:0] val);
		pending_numbers.push_back('{md, val, 1'b0});
	endfunction

	function automatic void queue_pause();
		pending_numbers.push_back('{3'd0, 64'd0, 1'b1});
	endfunction

	// Sender: payload only moves when the slot is empty or was just taken,
	// and num_valid gets at most one assignment per edge.
	always @(posedge clk or negedge arst_n) begin : sender
		logic         taken;
		logic         next_valid;
		number_item_t nxt;
		if (!arst_n) begin
			num_valid <= 1'b0;
			mode      <= '0;
			value     <= '0;
		end else begin
			taken = num_valid && !num_stall;
			if (taken) begin
				format_number(mode, value);
				numbers_taken[mode]++;
			end
			if (!num_valid || taken) begin
				next_valid = 1'b0;
				if (pending_numbers.size() != 0) begin
					if (pending_numbers[0].hold) begin
						// hold off until every char in flight has been seen
						if (!taken && expected_chars.size() == 0)
							void'(pending_numbers.pop_front());
					end else if (quiet || $urandom_range(99) >= IDLE_PCT) begin
						nxt = pending_numbers.pop_front();
						mode       <= nxt.md;
						value      <= nxt.val;
						next_valid = 1'b1;
					end
				end
				num_valid <= next_valid;
			end
		end
	end

	// Receiver: random stall, every taken char checked against the oldest one queued
	always @(posedge clk or negedge arst_n) begin : receiver
		char_item_t want;
		if (!arst_n) begin
			char_stall <= 1'b0;
		end else begin
			if (char_valid && !char_stall) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected char %h count %0d last %b", $realtime,
							char_code, char_count, last_char);
				end else begin
					want = expected_chars.pop_front();
					if (char_code !== want.code || char_count !== want.count ||
							last_char !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: char mismatch: expected %h/%0d/%b, got %h/%0d/%b",
								$realtime, want.code, want.count, want.last,
								char_code, char_count, last_char);
					end
				end
			end
			char_stall <= !quiet && $urandom_range(99) < IDLE_PCT;
		end
	end

	initial begin : stimulus
		int counted;
		logic [2:0] md;

		// directed: field extremes, every mode, sign and zero cases
		queue_number(itoa_pkg::MODE_SDEC, 64'd0);
		queue_number(itoa_pkg::MODE_SDEC, 64'd1);
		queue_number(itoa_pkg::MODE_SDEC, 64'h0000_0000_FFFF_FFFF);      // -1
		queue_number(itoa_pkg::MODE_SDEC, 64'h0000_0000_8000_0000);      // most negative
		queue_number(itoa_pkg::MODE_SDEC, 64'hDEAD_BEEF_8000_0000);      // same, junk above
		queue_number(itoa_pkg::MODE_SDEC, 64'h0000_0000_7FFF_FFFF);
		queue_number(itoa_pkg::MODE_UDEC, 64'd0);
		queue_number(itoa_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(itoa_pkg::MODE_UDEC, 64'd10);
		queue_number(itoa_pkg::MODE_UDEC, 64'hFFFF_FFFF_0000_0000);      // upper bits ignored
		queue_number(itoa_pkg::MODE_LHEX, 64'd0);
		queue_number(itoa_pkg::MODE_LHEX, 64'h0000_0000_FFFF_FFFF);
		queue_number(itoa_pkg::MODE_LHEX, 64'h1234_5678_ABCD_EF01);
		queue_number(itoa_pkg::MODE_UHEX, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(itoa_pkg::MODE_UHEX, 64'h0000_0000_00A5_C3E9);
		queue_number(itoa_pkg::MODE_UHEX, 64'd0);
		queue_number(itoa_pkg::MODE_PTR,  64'd0);                         // 0x0
		queue_number(itoa_pkg::MODE_PTR,  64'hFFFF_FFFF_FFFF_FFFF);      // longest output
		queue_number(itoa_pkg::MODE_PTR,  64'h8000_0000_0000_0000);
		queue_number(itoa_pkg::MODE_PTR,  64'd1);
		queue_number(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);           // unused modes
		queue_number(3'd6, 64'd0);
		queue_number(3'd7, {$urandom, $urandom});
		queue_pause();

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 6) begin
				md = 3'($urandom_range(5, 7));
			end else begin
				md = 3'($urandom_range(4));
				counted++;
			end
			queue_number(md, rand_value());
			if (counted == RANDOM_ITEMS / 2 && $urandom_range(1) == 1)
				queue_pause();
		end
		queue_pause();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || num_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		// decimal conversion is the slowest path
		repeat (100) @(posedge clk);

		$display("Covered %0d signed, %0d unsigned, %0d hex, %0d pointer and %0d unused items;",
			numbers_taken[itoa_pkg::MODE_SDEC], numbers_taken[itoa_pkg::MODE_UDEC],
			numbers_taken[itoa_pkg::MODE_LHEX] + numbers_taken[itoa_pkg::MODE_UHEX],
			numbers_taken[itoa_pkg::MODE_PTR],
			numbers_taken[5] + numbers_taken[6] + numbers_taken[7]);
		$display("%0d chars checked in %0d cycles, %0d mismatches.",
			chars_checked, cycle_count, mismatch_count);
		if (mismatch_count == 0 && expected_chars.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
